// ===== rtl/rgb_median_filter_3x3_core_assert.svh =====
// Assertion macros for the 3x3 median filter core.
// The including module supplies clk_i and rst_ni.
`ifndef RGB_MEDIAN_FILTER_3X3_CORE_ASSERT_SVH
`define RGB_MEDIAN_FILTER_3X3_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMF3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmf3_pkg.sv =====
package rmf3_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PIX_W      = 3 * CHAN_W;
  localparam int unsigned WIN_N      = 9;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] median_red;
    logic [CHAN_W-1:0] median_green;
    logic [CHAN_W-1:0] median_blue;
    logic              frame_end;
  } pix_res_t;

endpackage

// ===== rtl/rmf3_ram.sv =====
module rmf3_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rmf3_median.sv =====
module rmf3_median (
  input  logic [rmf3_pkg::WIN_N-1:0][rmf3_pkg::CHAN_W-1:0] vals_i,
  input  logic [rmf3_pkg::WIN_N-1:0]                       mask_i,
  input  logic [2:0]                                       k_i,
  output logic [rmf3_pkg::CHAN_W-1:0]                      med_o
);

  logic [rmf3_pkg::WIN_N-1:0] sel;

  // Rank each value, ties broken by position; pick the one at rank k.
  always_comb begin
    logic [3:0] rank;
    sel = '0;
    for (int i = 0; i < rmf3_pkg::WIN_N; i++) begin
      rank = '0;
      for (int j = 0; j < rmf3_pkg::WIN_N; j++) begin
        if (j != i && mask_i[j] &&
            ((vals_i[j] < vals_i[i]) || ((vals_i[j] == vals_i[i]) && (j < i)))) begin
          rank = rank + 4'd1;
        end
      end
      sel[i] = mask_i[i] && (rank == {1'b0, k_i});
    end
  end

  always_comb begin
    med_o = '0;
    for (int i = 0; i < rmf3_pkg::WIN_N; i++) begin
      med_o = med_o | (vals_i[i] & {rmf3_pkg::CHAN_W{sel[i]}});
    end
  end

endmodule

// ===== rtl/rgb_median_filter_3x3_core.sv =====
// Channel   Handshake                     Payload
// in        in_valid_i / in_stall_o       in_req_i   (rmf3_pkg::pix_req_t)
// out       out_valid_o / out_stall_i     out_res_o  (rmf3_pkg::pix_res_t)
// cfg       cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// One request per clock unless stalled; results pass the stage 1, 2 and output registers.
// The rate is set by the line store: one read and one write-back per clock,
// with the previous write forwarded when a read hits its column, as when a row is one pixel wide.
// Reset clears the position counters and the window; the line store needs none.
// A stalled output holding a result freezes the whole pipeline and the input stalls with it.
module rgb_median_filter_3x3_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rmf3_pkg::pix_req_t                  in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rmf3_pkg::pix_res_t                  out_res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rmf3_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rmf3_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  `include "rgb_median_filter_3x3_core_assert.svh"

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW = ((AW > rmf3_pkg::WIDTH_W) ? AW : rmf3_pkg::WIDTH_W) + 1;
  localparam int unsigned RW   = rmf3_pkg::HEIGHT_W + 1;
  localparam int unsigned PW   = rmf3_pkg::PIX_W;
  localparam int unsigned CW   = rmf3_pkg::CHAN_W;

  // ---------------- configuration ----------------
  logic [rmf3_pkg::WIDTH_W-1:0]  frame_width_q;
  logic [rmf3_pkg::HEIGHT_W-1:0] frame_height_q;
  logic                          cfg_we;
  logic [rmf3_pkg::WIDTH_W-1:0]  w_eff;
  logic [rmf3_pkg::HEIGHT_W-1:0] h_eff;
  logic [CMPW-1:0]               w_c;
  logic [CMPW-1:0]               w_p1;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rmf3_pkg::WIDTH_RST;
      frame_height_q <= rmf3_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index_i == rmf3_pkg::CFG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[rmf3_pkg::WIDTH_W-1:0];
      end
      if (cfg_index_i == rmf3_pkg::CFG_FRAME_HEIGHT) begin
        frame_height_q <= cfg_data_i[rmf3_pkg::HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (frame_width_q == '0) begin
      w_eff = rmf3_pkg::WIDTH_W'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = rmf3_pkg::WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
  end

  assign h_eff = (frame_height_q == '0) ? rmf3_pkg::HEIGHT_W'(1) : frame_height_q;
  assign w_c   = CMPW'(w_eff);
  assign w_p1  = w_c + CMPW'(1);

  // ---------------- pipeline control ----------------
  logic adv;
  logic accept;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i & adv;

  // ---------------- stage 0: position tracking, line store read ----------------
  logic [AW-1:0]                 in_column_q, in_column_d;
  logic [RW-1:0]                 in_row_q, in_row_d;
  logic [CMPW-1:0]               fill_q, fill_d;
  logic [rmf3_pkg::HEIGHT_W-1:0] crow_q, crow_d;
  logic [AW-1:0]                 ccol_q, ccol_d;

  logic                          row_ok;
  logic [PW-1:0]                 pix0;
  logic                          has_res0;
  logic                          top_ok, bot_ok, left_ok, right_ok;
  logic                          fe0;
  logic [2:0]                    row_ok_v, col_ok_v;
  logic [rmf3_pkg::WIN_N-1:0]    mask0;
  logic [1:0]                    nrows, ncols;
  logic [3:0]                    n0;

  assign row_ok   = in_row_q < RW'(h_eff);
  assign pix0     = ((in_req_i.req_type == rmf3_pkg::REQ_PIXEL) && row_ok) ?
                    {in_req_i.red_in, in_req_i.green_in, in_req_i.blue_in} : '0;
  assign has_res0 = (fill_q == w_p1);

  assign top_ok   = (crow_q != '0);
  assign bot_ok   = (RW'(crow_q) + RW'(1)) < RW'(h_eff);
  assign left_ok  = (ccol_q != '0);
  assign right_ok = (CMPW'(ccol_q) + CMPW'(1)) < w_c;
  assign fe0      = (crow_q == (h_eff - rmf3_pkg::HEIGHT_W'(1))) &&
                    (CMPW'(ccol_q) == (w_c - CMPW'(1)));

  assign row_ok_v = {bot_ok, 1'b1, top_ok};
  assign col_ok_v = {right_ok, 1'b1, left_ok};
  assign nrows    = 2'd1 + 2'(top_ok) + 2'(bot_ok);
  assign ncols    = 2'd1 + 2'(left_ok) + 2'(right_ok);
  assign n0       = 4'(nrows) * 4'(ncols);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask0[r*3+c] = row_ok_v[r] & col_ok_v[c];
      end
    end
  end

  always_comb begin
    in_column_d = in_column_q;
    in_row_d    = in_row_q;
    fill_d      = fill_q;
    crow_d      = crow_q;
    ccol_d      = ccol_q;
    if (cfg_we) begin
      in_column_d = '0;
      in_row_d    = '0;
      fill_d      = '0;
      crow_d      = '0;
      ccol_d      = '0;
    end else if (accept) begin
      if ((CMPW'(in_column_q) + CMPW'(1)) >= w_c) begin
        in_column_d = '0;
        in_row_d    = in_row_q + RW'(1);
      end else begin
        in_column_d = in_column_q + AW'(1);
      end
      if (has_res0) begin
        if (fe0) begin
          // last result of the frame: restart everything
          in_column_d = '0;
          in_row_d    = '0;
          fill_d      = '0;
          crow_d      = '0;
          ccol_d      = '0;
        end else if (!right_ok) begin
          ccol_d = '0;
          crow_d = crow_q + rmf3_pkg::HEIGHT_W'(1);
        end else begin
          ccol_d = ccol_q + AW'(1);
        end
      end else begin
        fill_d = fill_q + CMPW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q <= '0;
      in_row_q    <= '0;
      fill_q      <= '0;
      crow_q      <= '0;
      ccol_q      <= '0;
    end else begin
      in_column_q <= in_column_d;
      in_row_q    <= in_row_d;
      fill_q      <= fill_d;
      crow_q      <= crow_d;
      ccol_q      <= ccol_d;
    end
  end

  // ---------------- stage 1: line store write-back, window shift ----------------
  logic [AW-1:0]              s1_col_q;
  logic [PW-1:0]              s1_pix_q;
  logic                       s1_has_res_q;
  logic [rmf3_pkg::WIN_N-1:0] s1_mask_q;
  logic [2:0]                 s1_k_q;
  logic                       s1_fe_q;
  logic                       fwd_q;
  logic [2*PW-1:0]            fwd_data_q;
  logic [2*PW-1:0]            ram_rdata;
  logic [2*PW-1:0]            s1_rd;
  logic [PW-1:0]              s1_up, s1_mid;
  logic                       ram_we;
  logic                       fwd_d;

  assign s1_rd  = fwd_q ? fwd_data_q : ram_rdata;
  assign s1_up  = s1_rd[2*PW-1:PW];
  assign s1_mid = s1_rd[PW-1:0];
  assign ram_we = adv & s1_valid_q;
  // same column read while being written: take the write data instead
  assign fwd_d  = accept && ram_we && (in_column_q == s1_col_q);

  rmf3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i ({s1_mid, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (in_column_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q     <= in_column_q;
      s1_pix_q     <= pix0;
      s1_has_res_q <= has_res0;
      s1_mask_q    <= mask0;
      s1_k_q       <= n0[3:1];
      s1_fe_q      <= fe0;
      fwd_q        <= fwd_d;
      fwd_data_q   <= {s1_mid, s1_pix_q};
    end
  end

  // ---------------- stage 2: median selection ----------------
  logic [rmf3_pkg::WIN_N-1:0][PW-1:0] window_q, window_d;
  logic                               s2_has_res_q;
  logic [rmf3_pkg::WIN_N-1:0]         s2_mask_q;
  logic [2:0]                         s2_k_q;
  logic                               s2_fe_q;

  always_comb begin
    window_d = window_q;
    for (int r = 0; r < 3; r++) begin
      window_d[r*3]   = window_q[r*3+1];
      window_d[r*3+1] = window_q[r*3+2];
    end
    window_d[2] = s1_up;
    window_d[5] = s1_mid;
    window_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      window_q   <= '0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        window_q <= window_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_has_res_q <= s1_has_res_q;
      s2_mask_q    <= s1_mask_q;
      s2_k_q       <= s1_k_q;
      s2_fe_q      <= s1_fe_q;
    end
  end

  logic [rmf3_pkg::WIN_N-1:0][CW-1:0] red_v, green_v, blue_v;
  logic [CW-1:0]                      med_red, med_green, med_blue;

  always_comb begin
    for (int i = 0; i < rmf3_pkg::WIN_N; i++) begin
      red_v[i]   = window_q[i][3*CW-1:2*CW];
      green_v[i] = window_q[i][2*CW-1:CW];
      blue_v[i]  = window_q[i][CW-1:0];
    end
  end

  rmf3_median u_med_red (
    .vals_i (red_v),
    .mask_i (s2_mask_q),
    .k_i    (s2_k_q),
    .med_o  (med_red)
  );

  rmf3_median u_med_green (
    .vals_i (green_v),
    .mask_i (s2_mask_q),
    .k_i    (s2_k_q),
    .med_o  (med_green)
  );

  rmf3_median u_med_blue (
    .vals_i (blue_v),
    .mask_i (s2_mask_q),
    .k_i    (s2_k_q),
    .med_o  (med_blue)
  );

  // ---------------- output register ----------------
  rmf3_pkg::pix_res_t out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q & s2_has_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q && s2_has_res_q) begin
      out_res_q.median_red   <= med_red;
      out_res_q.median_green <= med_green;
      out_res_q.median_blue  <= med_blue;
      out_res_q.frame_end    <= s2_fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // ---------------- assertions ----------------
  `RMF3_ASSERT_IMPL(a_crow_range, 1'b1, crow_q < h_eff, "centre row outside frame")
  `RMF3_ASSERT_IMPL(a_ccol_range, 1'b1, CMPW'(ccol_q) < w_c, "centre column outside row")
  `RMF3_ASSERT_IMPL(a_incol_range, 1'b1, CMPW'(in_column_q) < w_c, "input column outside row")
  `RMF3_ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= w_p1, "fill count overran")
  `RMF3_ASSERT_NEXT(a_fwd_hold, !adv, fwd_q == $past(fwd_q), "forward flag moved while frozen")

endmodule

// ===== verif/tb_rgb_median_filter_3x3_core.sv =====
module tb_rgb_median_filter_3x3_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W       = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 10;

  class median_scoreboard;
    logic [rmf3_pkg::PIX_W-1:0]    row_two_back [MAX_W];
    logic [rmf3_pkg::PIX_W-1:0]    row_one_back [MAX_W];
    logic [rmf3_pkg::PIX_W-1:0]    window [rmf3_pkg::WIN_N];
    int unsigned                   in_col;
    int unsigned                   in_row;
    int unsigned                   out_pos;
    logic [rmf3_pkg::WIDTH_W-1:0]  width_reg;
    logic [rmf3_pkg::HEIGHT_W-1:0] height_reg;
    rmf3_pkg::pix_res_t            expected_medians [$];
    int                            errors;

    function new();
      foreach (row_two_back[i]) row_two_back[i] = '0;
      foreach (row_one_back[i]) row_one_back[i] = '0;
      foreach (window[i]) window[i] = '0;
      width_reg  = rmf3_pkg::WIDTH_RST;
      height_reg = rmf3_pkg::HEIGHT_RST;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_pos = 0;
    endfunction

    function void write_reg(logic [rmf3_pkg::CFG_IDX_W-1:0] idx,
                            logic [rmf3_pkg::CFG_DATA_W-1:0] data);
      if (idx == rmf3_pkg::CFG_FRAME_WIDTH) begin
        width_reg = data[rmf3_pkg::WIDTH_W-1:0];
        restart();
      end else if (idx == rmf3_pkg::CFG_FRAME_HEIGHT) begin
        height_reg = data[rmf3_pkg::HEIGHT_W-1:0];
        restart();
      end
    endfunction

    function logic [rmf3_pkg::CHAN_W-1:0] median(logic [rmf3_pkg::CHAN_W-1:0] v [rmf3_pkg::WIN_N],
                                                 int n);
      logic [rmf3_pkg::CHAN_W-1:0] t;
      int j;
      for (int i = 1; i < n; i++) begin
        t = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > t) begin
          v[j+1] = v[j];
          j--;
        end
        v[j+1] = t;
      end
      return v[n/2];
    endfunction

    function void note_request(rmf3_pkg::pix_req_t req);
      int unsigned w, h, total, pos, c, q, crow, ccol;
      int rr, cc, n;
      logic [rmf3_pkg::PIX_W-1:0] pix, up, mid, v;
      logic [rmf3_pkg::CHAN_W-1:0] rv [rmf3_pkg::WIN_N], gv [rmf3_pkg::WIN_N];
      logic [rmf3_pkg::CHAN_W-1:0] bv [rmf3_pkg::WIN_N];
      rmf3_pkg::pix_res_t res;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      total = w * h;
      pos = in_row * w + in_col;
      pix = '0;
      // flushes and pixels past the frame end carry zero
      if (req.req_type == rmf3_pkg::REQ_PIXEL && in_row < h)
        pix = {req.red_in, req.green_in, req.blue_in};
      c = in_col;
      up = row_two_back[c];
      mid = row_one_back[c];
      row_two_back[c] = mid;
      row_one_back[c] = pix;
      for (int r = 0; r < 3; r++) begin
        window[r*3] = window[r*3+1];
        window[r*3+1] = window[r*3+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (pos < w + 1) return;
      q = out_pos;
      crow = q / w;
      ccol = q % w;
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        rr = int'(crow) + dr;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int dc = -1; dc <= 1; dc++) begin
          cc = int'(ccol) + dc;
          if (cc < 0 || cc >= int'(w)) continue;
          v = window[(dr+1)*3 + (dc+1)];
          rv[n] = v[23:16];
          gv[n] = v[15:8];
          bv[n] = v[7:0];
          n++;
        end
      end
      res.median_red   = median(rv, n);
      res.median_green = median(gv, n);
      res.median_blue  = median(bv, n);
      res.frame_end    = (q + 1 >= total);
      expected_medians.push_back(res);
      out_pos++;
      if (q + 1 >= total) restart();
    endfunction

    function void check_result(rmf3_pkg::pix_res_t got);
      rmf3_pkg::pix_res_t exp_res;
      if (expected_medians.size() == 0) begin
        $error("unexpected result %h with nothing pending", got);
        errors++;
        return;
      end
      exp_res = expected_medians.pop_front();
      if (got.median_red !== exp_res.median_red) begin
        $error("median_red: expected %0d, got %0d", exp_res.median_red, got.median_red);
        errors++;
      end
      if (got.median_green !== exp_res.median_green) begin
        $error("median_green: expected %0d, got %0d", exp_res.median_green, got.median_green);
        errors++;
      end
      if (got.median_blue !== exp_res.median_blue) begin
        $error("median_blue: expected %0d, got %0d", exp_res.median_blue, got.median_blue);
        errors++;
      end
      if (got.frame_end !== exp_res.frame_end) begin
        $error("frame_end: expected %0d, got %0d", exp_res.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  rmf3_pkg::pix_req_t              in_req_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  rmf3_pkg::pix_res_t              out_res_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [rmf3_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [rmf3_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  median_scoreboard   sb = new();
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        hold_left = 0;
  int unsigned        cycles = 0;
  logic               out_taken = 1'b0;
  rmf3_pkg::pix_res_t out_seen;

  rgb_median_filter_3x3_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // sample between edges so the check never races the DUT
  always @(negedge clk_i) begin
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    out_seen  = out_res_o;
  end

  always @(posedge clk_i) begin
    if (out_taken) sb.check_result(out_seen);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [rmf3_pkg::CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return rmf3_pkg::CHAN_W'($urandom());
    endcase
  endfunction

  function automatic rmf3_pkg::pix_req_t rand_req();
    rmf3_pkg::pix_req_t r;
    r.req_type = ($urandom_range(0, 11) == 0) ? rmf3_pkg::REQ_FLUSH : rmf3_pkg::REQ_PIXEL;
    r.red_in   = rand_chan();
    r.green_in = rand_chan();
    r.blue_in  = rand_chan();
    return r;
  endfunction

  task automatic send_request(rmf3_pkg::pix_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_request(rand_req());
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(logic [rmf3_pkg::CFG_IDX_W-1:0] idx,
                           logic [rmf3_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // drain, let the window settle, then reprogram the frame size
  task automatic set_frame(logic [rmf3_pkg::CFG_DATA_W-1:0] w,
                           logic [rmf3_pkg::CFG_DATA_W-1:0] h);
    while (sb.expected_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    write_reg(rmf3_pkg::CFG_FRAME_WIDTH, w);
    write_reg(rmf3_pkg::CFG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rmf3_pkg::pix_req_t r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 frame: corners see 4 values, edges 6, centre 9
    set_frame(12'd3, 12'd3);
    for (int i = 0; i < 14; i++) begin
      r.req_type = (i == 4 || i == 12) ? rmf3_pkg::REQ_FLUSH : rmf3_pkg::REQ_PIXEL;
      r.red_in   = (i % 2) ? 8'hFF : 8'h00;
      r.green_in = (i % 3) ? 8'h00 : 8'hFF;
      r.blue_in  = 8'(i * 37);
      if (i >= 9) r = '{rmf3_pkg::REQ_PIXEL, 8'hAA, 8'h55, 8'hFF};
      send_request(r);
    end
    in_valid_i <= 1'b0;

    // zero sizes fall back to one pixel
    set_frame(12'd0, 12'd0);
    send_random(6);
    // width beyond the line store saturates; tallest frame
    set_frame(12'd2047, 12'd4095);
    send_random(30);
    set_frame(12'd1, 12'd4095);
    send_random(40);
    set_frame(12'd2, 12'd1);
    send_random(12);

    for (int p = 0; p < 14; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      set_frame({1'($urandom_range(0, 1)), 11'($urandom_range(1, 12))},
                12'($urandom_range(1, 8)));
      send_random($urandom_range(45, 75));
    end

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_frame(12'd5, 12'd5);
    hold_left = 300;
    send_random(120);

    while (sb.expected_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== rgb_median_filter_3x3_core.f =====
+incdir+rtl
rtl/rmf3_pkg.sv
rtl/rmf3_ram.sv
rtl/rmf3_median.sv
rtl/rgb_median_filter_3x3_core.sv
verif/tb_rgb_median_filter_3x3_core.sv
